// ===== hdl/efr_pkg.sv =====
// shared constants, register codes, result codes and types for the efficiency ratio block
// no dependencies; compile first
package efr_pkg;

  localparam int PRICE_BITS = 32;
  localparam int MAX_WINDOW = 256;
  localparam int RING_DEPTH = MAX_WINDOW + 1;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W      = PRICE_BITS + $clog2(MAX_WINDOW);

  // ratio format: unsigned q1.16
  localparam int FRAC_W = 16;
  localparam int QW     = FRAC_W + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1 << FRAC_W);

  // configuration port
  localparam int WIN_W     = 9;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TH_VHI  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TH_HI   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TH_MED  = CFG_IDX_W'(3);

  localparam logic [WIN_W-1:0] WIN_RST    = WIN_W'(10);
  localparam logic [CFG_W-1:0] TH_VHI_RST = CFG_W'(45875);
  localparam logic [CFG_W-1:0] TH_HI_RST  = CFG_W'(32768);
  localparam logic [CFG_W-1:0] TH_MED_RST = CFG_W'(19661);

  // efficiency level codes
  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MED  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;
  localparam logic [1:0] LVL_VHI  = 2'd3;

  // market state codes
  localparam logic [1:0] MS_NEUTRAL = 2'd0;
  localparam logic [1:0] MS_CHOPPY  = 2'd1;
  localparam logic [1:0] MS_TRANS   = 2'd2;
  localparam logic [1:0] MS_TREND   = 2'd3;

  // divider status toward the control fsm
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/efr_if.sv =====
// request channel interfaces for price samples and ratio results
// depends on efr_pkg for field widths
interface efr_in_if;
  logic                           valid;
  logic                           ready;
  logic [efr_pkg::PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface efr_out_if;
  logic                   valid;
  logic                   ready;
  logic                   ready_res;
  logic [efr_pkg::QW-1:0] ratio;
  logic [1:0]             efficiency_level;
  logic [1:0]             mkt_state;

  modport source (output valid, output ready_res, output ratio,
                  output efficiency_level, output mkt_state, input ready);
  modport sink   (input valid, input ready_res, input ratio,
                  input efficiency_level, input mkt_state, output ready);
endinterface

// ===== hdl/efr_div.sv =====
// restoring divider, one quotient bit per cycle: (change << 16) / sum
// depends on efr_pkg; expects change <= sum so the quotient fits q1.16
module efr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [efr_pkg::PRICE_BITS-1:0] dividend,
  input  logic [efr_pkg::SUM_W-1:0]      divisor,
  output efr_pkg::div_stat_t             stat,
  output logic [efr_pkg::QW-1:0]         quot
);

  localparam int CW = $clog2(efr_pkg::QW);

  logic                      busy_r, busy_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [efr_pkg::SUM_W-1:0] rem_r, rem_nxt;
  logic [efr_pkg::QW-1:0]    dlo_r, dlo_nxt;
  logic [efr_pkg::QW-1:0]    q_r, q_nxt;

  logic [efr_pkg::SUM_W:0]   trial;
  logic [efr_pkg::SUM_W:0]   diff;
  logic                      ge;
  logic                      last;

  assign trial = {rem_r, dlo_r[efr_pkg::QW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});
  assign last  = (cnt_r == CW'(efr_pkg::QW - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dlo_nxt  = dlo_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // top bits of the dividend already sit below the divisor
      rem_nxt  = efr_pkg::SUM_W'(dividend >> 1);
      dlo_nxt  = {dividend[0], {efr_pkg::FRAC_W{1'b0}}};
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[efr_pkg::SUM_W-1:0] : trial[efr_pkg::SUM_W-1:0];
      dlo_nxt  = {dlo_r[efr_pkg::QW-2:0], 1'b0};
      q_nxt    = {q_r[efr_pkg::QW-2:0], ge};
      cnt_nxt  = cnt_r + CW'(1);
      if (last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dlo_r <= dlo_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && last;
  assign quot      = q_r;

endmodule

// ===== hdl/efficiency_ratio_stream_core.sv =====
// efficiency ratio over a sliding window of price samples, price ring in one sync ram
// depends on efr_pkg, efr_if (efr_in_if, efr_out_if) and efr_div
//
//  channel  dir  handshake           payload
//  in_ch    in   valid/ready         price[31:0]
//  out_ch   out  valid/ready         ready_res, ratio[16:0], efficiency_level, mkt_state
//  cfg_*    in   cfg_we, no stall    cfg_idx[2:0], cfg_data[16:0]
//
// one request at a time: after accept, S_RPREV, S_RCUR, S_RNXT, S_STEP and S_SUM do the
// ring reads and writes; once the window is full the 17-step restoring divider runs in
// S_DIV, then S_FIN classifies and loads the result; before the window is full S_DIV is skipped
// in_ch takes a new request in the cycle after the result is loaded, even while
// out_ch is still stalled; a stalled result holds only the finish step
// reset is synchronous, clears fill count, pointer, sum and loads register defaults;
// the ring ram is not cleared; read data is used only from entries already written
module efficiency_ratio_stream_core (
  input  logic                             clk,
  input  logic                             rst_n,
  efr_in_if.sink                           in_ch,
  efr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [efr_pkg::CFG_W-1:0]        cfg_data
);

  localparam int PB = efr_pkg::PRICE_BITS;
  localparam int AW = efr_pkg::ADDR_W;
  localparam int CW = efr_pkg::CNT_W;
  localparam int SW = efr_pkg::SUM_W;
  localparam int QW = efr_pkg::QW;

  // control sequencer, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // wait for a request
    S_RPREV = 8'b0000_0010,  // read newest stored price
    S_RCUR  = 8'b0000_0100,  // read slot to overwrite, add incoming step
    S_RNXT  = 8'b0000_1000,  // read second oldest price
    S_STEP  = 8'b0001_0000,  // leaving step and net change, write new price
    S_SUM   = 8'b0010_0000,  // drop leaving step, advance pointer, start divide
    S_DIV   = 8'b0100_0000,  // divider running
    S_FIN   = 8'b1000_0000   // classify and load result
  } state_t;

  function automatic logic [PB-1:0] absdiff(input logic [PB-1:0] a, input logic [PB-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // configuration
  logic [efr_pkg::WIN_W-1:0] win_len_r, win_len_nxt;
  logic [efr_pkg::CFG_W-1:0] th_vhi_r, th_vhi_nxt;
  logic [efr_pkg::CFG_W-1:0] th_hi_r, th_hi_nxt;
  logic [efr_pkg::CFG_W-1:0] th_med_r, th_med_nxt;

  // window state
  state_t         state_r, state_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic           full_r, full_nxt;

  // per-request working values
  logic [PB-1:0]  price_r, price_nxt;
  logic [PB-1:0]  cur_q_r, cur_q_nxt;
  logic [PB-1:0]  step_out_r, step_out_nxt;
  logic [PB-1:0]  change_r, change_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic           out_rdy_res_r, out_rdy_res_nxt;
  logic [QW-1:0]  out_ratio_r, out_ratio_nxt;
  logic [1:0]     out_level_r, out_level_nxt;
  logic [1:0]     out_mstate_r, out_mstate_nxt;

  // price ring
  logic [PB-1:0]  ring_mem [efr_pkg::RING_DEPTH];
  logic [PB-1:0]  rd_q;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;

  // effective period and ring geometry
  logic [AW-1:0]  len;
  logic [CW-1:0]  slots;
  logic [AW-1:0]  prev_addr;
  logic [CW-1:0]  nxt_cnt;
  logic [AW-1:0]  nxt_addr;

  // divider
  logic               div_start;
  efr_pkg::div_stat_t div_stat;
  logic [QW-1:0]      div_quot;

  // classification
  logic [QW-1:0]  ratio_fin;
  logic [1:0]     level_fin;
  logic [1:0]     mstate_fin;

  logic           in_acc;
  logic           out_free;

  // period of zero acts as one, above MAX_WINDOW it saturates to MAX_WINDOW
  always_comb begin
    if (win_len_r == '0) begin
      len = AW'(1);
    end else if (int'(win_len_r) > efr_pkg::MAX_WINDOW) begin
      len = AW'(efr_pkg::MAX_WINDOW);
    end else begin
      len = AW'(win_len_r);
    end
  end

  assign slots     = CW'(len) + CW'(1);
  assign prev_addr = (ptr_r == '0) ? len : (ptr_r - AW'(1));
  assign nxt_cnt   = CW'(ptr_r) + CW'(1);
  assign nxt_addr  = (nxt_cnt == slots) ? '0 : nxt_cnt[AW-1:0];

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // read address follows the sequencer; read data is registered and comes back in the cycle after
  always_comb begin
    unique case (state_r)
      S_RPREV: rd_addr = prev_addr;
      S_RNXT:  rd_addr = nxt_addr;
      default: rd_addr = ptr_r;
    endcase
  end

  assign mem_we = (state_r == S_STEP);

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[ptr_r] <= price_r;
    rd_q <= ring_mem[rd_addr];
  end

  // divide only once the window is full; the divisor is sampled after the sum update
  assign div_start = (state_r == S_SUM) && (fill_r >= slots - CW'(1));

  efr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (change_r),
    .divisor  (sum_r),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  // not ready gives zero; no movement gives zero and falls to choppy below
  always_comb begin
    if (!full_r || (sum_r == '0)) begin
      ratio_fin = '0;
    end else if (div_quot > efr_pkg::ONE_Q) begin
      ratio_fin = efr_pkg::ONE_Q;
    end else begin
      ratio_fin = div_quot;
    end
  end

  always_comb begin
    if (!full_r) begin
      level_fin  = efr_pkg::LVL_LOW;
      mstate_fin = efr_pkg::MS_NEUTRAL;
    end else if (ratio_fin > th_vhi_r) begin
      level_fin  = efr_pkg::LVL_VHI;
      mstate_fin = efr_pkg::MS_TREND;
    end else if (ratio_fin > th_hi_r) begin
      level_fin  = efr_pkg::LVL_HIGH;
      mstate_fin = efr_pkg::MS_TREND;
    end else if (ratio_fin > th_med_r) begin
      level_fin  = efr_pkg::LVL_MED;
      mstate_fin = efr_pkg::MS_TRANS;
    end else begin
      level_fin  = efr_pkg::LVL_LOW;
      mstate_fin = efr_pkg::MS_CHOPPY;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    fill_nxt        = fill_r;
    sum_nxt         = sum_r;
    full_nxt        = full_r;
    price_nxt       = price_r;
    cur_q_nxt       = cur_q_r;
    step_out_nxt    = step_out_r;
    change_nxt      = change_r;
    win_len_nxt     = win_len_r;
    th_vhi_nxt      = th_vhi_r;
    th_hi_nxt       = th_hi_r;
    th_med_nxt      = th_med_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_rdy_res_nxt = out_rdy_res_r;
    out_ratio_nxt   = out_ratio_r;
    out_level_nxt   = out_level_r;
    out_mstate_nxt  = out_mstate_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          price_nxt = in_ch.price;
          state_nxt = S_RPREV;
        end
      end
      S_RPREV: state_nxt = S_RCUR;
      S_RCUR: begin
        // rd_q holds the newest stored price
        if (fill_r != '0) sum_nxt = sum_r + SW'(absdiff(price_r, rd_q));
        state_nxt = S_RNXT;
      end
      S_RNXT: begin
        cur_q_nxt = rd_q;  // oldest price, about to be overwritten
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // rd_q holds the second oldest price, the oldest one after this write
        step_out_nxt = absdiff(rd_q, cur_q_r);
        change_nxt   = absdiff(price_r, rd_q);
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        if (fill_r >= slots) sum_nxt = sum_r - SW'(step_out_r);
        if (fill_r < slots) fill_nxt = fill_r + CW'(1);
        ptr_nxt   = nxt_addr;
        full_nxt  = (fill_r >= slots - CW'(1));
        state_nxt = div_start ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_stat.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_rdy_res_nxt = full_r;
          out_ratio_nxt   = ratio_fin;
          out_level_nxt   = level_fin;
          out_mstate_nxt  = mstate_fin;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // the user must write only while idle, the block does not enforce it; any period write restarts the window
    if (cfg_we) begin
      unique case (cfg_idx)
        efr_pkg::REG_WINDOW: begin
          win_len_nxt = cfg_data[efr_pkg::WIN_W-1:0];
          fill_nxt    = '0;
          ptr_nxt     = '0;
          sum_nxt     = '0;
        end
        efr_pkg::REG_TH_VHI: th_vhi_nxt = cfg_data;
        efr_pkg::REG_TH_HI:  th_hi_nxt  = cfg_data;
        efr_pkg::REG_TH_MED: th_med_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      win_len_r   <= efr_pkg::WIN_RST;
      th_vhi_r    <= efr_pkg::TH_VHI_RST;
      th_hi_r     <= efr_pkg::TH_HI_RST;
      th_med_r    <= efr_pkg::TH_MED_RST;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      win_len_r   <= win_len_nxt;
      th_vhi_r    <= th_vhi_nxt;
      th_hi_r     <= th_hi_nxt;
      th_med_r    <= th_med_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r       <= price_nxt;
    cur_q_r       <= cur_q_nxt;
    step_out_r    <= step_out_nxt;
    change_r      <= change_nxt;
    out_rdy_res_r <= out_rdy_res_nxt;
    out_ratio_r   <= out_ratio_nxt;
    out_level_r   <= out_level_nxt;
    out_mstate_r  <= out_mstate_nxt;
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.ready_res        = out_rdy_res_r;
  assign out_ch.ratio            = out_ratio_r;
  assign out_ch.efficiency_level = out_level_r;
  assign out_ch.mkt_state        = out_mstate_r;

`ifndef SYNTHESIS
  // fill count saturates at the ring size of the current period
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= slots)
    else $error("fill count beyond window size");

  // pointer stays inside the active part of the ring
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(ptr_r) < slots)
    else $error("ring pointer outside active slots");

  // a result appears only from the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish step");

  // a result before the window is full is neutral with zero ratio
  a_not_ready_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rdy_res_r) |->
      (out_ratio_r == '0) && (out_mstate_r == efr_pkg::MS_NEUTRAL))
    else $error("not-ready result carries a ratio or state");

  // the divider runs only while the sequencer waits on it
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide step");
`endif

endmodule
